@@ rtl/overlap_hit_pair_cluster_labeler_defines.svh @@
// ----------------------------------------------------------------------------
// Overlap hit-pair cluster labeler: assertion macros
// Shared check wrappers. All are clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_HIT_PAIR_CLUSTER_LABELER_DEFINES_SVH
`define OVERLAP_HIT_PAIR_CLUSTER_LABELER_DEFINES_SVH

// Condition holds in every cycle out of reset.
`define OHPCL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define OHPCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ohpcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohpcl_pkg
// Types and constants of the overlap hit-pair cluster labeler.
// ----------------------------------------------------------------------------
package ohpcl_pkg;

  localparam int unsigned ZW    = 18;
  localparam int unsigned RW    = 17;
  localparam int unsigned PHIW  = 16;
  localparam int unsigned MODW  = 20;
  localparam int unsigned CELLW = 8;
  localparam int unsigned OUTIW = 6;
  localparam int unsigned CFGW  = 20;
  localparam int unsigned CFGAW = 2;
  localparam int unsigned MULW  = 19;          // signed multiplier operand
  localparam int unsigned PRODW = 2 * MULW;

  localparam logic [CFGAW-1:0] CFG_CELL_CUT = 2'd0;
  localparam logic [CFGAW-1:0] CFG_PHI_WIN  = 2'd1;
  localparam logic [CFGAW-1:0] CFG_Z0_LIM   = 2'd2;
  localparam logic [CFGAW-1:0] CFG_PIXEL    = 2'd3;

  typedef struct packed {
    logic [ZW-1:0]    z;
    logic [RW-1:0]    r;
    logic [PHIW-1:0]  phi;
    logic [MODW-1:0]  module_id;
    logic [CELLW-1:0] cells;
    logic             ovl;
  } node_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_N1_RD, S_N1_LAT,
    S_N2_RD, S_N2_CHK,
    S_M_PHI, S_T_PHI, S_M_B, S_M_C, S_T_Z,
    S_SEEN_RD, S_SEEN_CMP,
    S_INIT,
    S_P_RD, S_P_LAB, S_P_WR,
    S_C_RD, S_C_WR,
    S_O_RD, S_O_EM
  } state_e;

endpackage

@@ rtl/overlap_hit_pair_cluster_labeler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_hit_pair_cluster_labeler
// Collects the hit nodes of one bin, finds qualifying overlap pairs with one
// shared multiplier, merges them by min-label sweeps and emits one merge
// target per node.
// ----------------------------------------------------------------------------
//
//  channel   handshake                    payload
//  --------  ---------------------------  ----------------------------------
//  node in   start_i & !busy_o            hit_z_i .. last_node_i
//  config    cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//  result    result_valid_o (1 cycle)     node_index_o .. last_result_o
//
//  A node that does not close the bin is stored while busy_o stays low.
//  Closing a bin runs the sequencer: the candidate pair search, with a scan
//  of the seen-module list for each passing pair, then label init, the
//  min-label sweeps and the results, one per node, each read then emitted.
//  The multiplier is the shared unit; MAX_SWEEPS caps the number of sweeps.
//  Reset clears control state and presets config; stores are not cleared.
//  Config words are taken only while idle. Results cannot be stalled.
//
module overlap_hit_pair_cluster_labeler #(
  parameter int unsigned MAX_NODES  = 64,
  parameter int unsigned MAX_PAIRS  = 256,
  parameter int unsigned MAX_SWEEPS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // node input
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ohpcl_pkg::ZW-1:0]          hit_z_i,
  input  logic [ohpcl_pkg::RW-1:0]          hit_r_i,
  input  logic [ohpcl_pkg::PHIW-1:0]        hit_phi_i,
  input  logic [ohpcl_pkg::MODW-1:0]        module_id_i,
  input  logic [ohpcl_pkg::CELLW-1:0]       cell_count_i,
  input  logic                              in_overlap_i,
  input  logic [ohpcl_pkg::RW-1:0]          surface_radius_i,
  input  logic                              last_node_i,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ohpcl_pkg::CFGAW-1:0]       cfg_index_i,
  input  logic [ohpcl_pkg::CFGW-1:0]        cfg_data_i,
  // results
  output logic                              result_valid_o,
  output logic [ohpcl_pkg::OUTIW-1:0]       node_index_o,
  output logic [ohpcl_pkg::OUTIW-1:0]       merge_target_o,
  output logic                              node_kept_o,
  output logic                              capacity_overflow_o,
  output logic                              last_result_o
);

  `include "overlap_hit_pair_cluster_labeler_defines.svh"

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned PW  = $clog2(MAX_PAIRS);
  localparam int unsigned PCW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned SW  = $clog2(MAX_SWEEPS);
  localparam int unsigned KW  = (PCW > CW) ? PCW : CW;
  localparam int unsigned MW  = ohpcl_pkg::MULW;
  localparam int unsigned PRW = ohpcl_pkg::PRODW;
  localparam int unsigned CELLW_LOC = ohpcl_pkg::CELLW;

  ohpcl_pkg::state_e state_q, state_d;

  // config
  logic [7:0]                     cell_cut_q;
  logic [ohpcl_pkg::CFGW-1:0]     phi_win_q;
  logic [ohpcl_pkg::RW-1:0]       z0_lim_q;
  logic                           pixel_q;

  // control
  logic [CW-1:0]  cnt_q, cnt_d;        // nodes in the bin
  logic [CW-1:0]  n1_q, n1_d, n2_q, n2_d, nseen_q, nseen_d;
  logic [KW-1:0]  k_q, k_d;
  logic [PCW-1:0] npairs_q, npairs_d;
  logic [SW-1:0]  sweeps_q, sweeps_d;
  logic           ovf_q, ovf_d, chg_q, chg_d;
  logic [ohpcl_pkg::RW-1:0] radius_q;

  // payload
  ohpcl_pkg::node_t node1_q, node2_q, node_rd_q;
  logic signed [PRW-1:0] prod_q, a_q, num_q;
  logic [NW-1:0] pa_q, pb_q;

  // memories
  ohpcl_pkg::node_t            node_mem [MAX_NODES];
  logic [2*NW-1:0]             pair_mem [MAX_PAIRS];
  logic [ohpcl_pkg::MODW-1:0]  seen_mem [MAX_NODES];
  logic [NW-1:0]               cur_mem  [MAX_NODES];
  logic [NW-1:0]               nxt_mem  [MAX_NODES];
  logic [2*NW-1:0]             pair_rd_q;
  logic [ohpcl_pkg::MODW-1:0]  seen_rd_q;
  logic [NW-1:0]               cur_rd0_q, cur_rd1_q, nxt_rd_q;

  logic accept, close;
  logic [NW-1:0] node_ra, cur_ra0, cur_ra1, cur_wa, nxt_wa;
  logic [NW-1:0] cur_wd, nxt_wd;
  logic cur_we, nxt_we, seen_we, pair_we;

  // multiplier
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] mul_p;
  logic signed [ohpcl_pkg::RW:0]   dphi, den;
  logic [ohpcl_pkg::RW-1:0]        dphi_abs, den_abs;
  logic signed [PRW-1:0]           num_abs;
  logic [CELLW_LOC-1:0] c1, c2, cmax, cdiff;
  logic cell_fail;

  assign accept      = start_i && (state_q == ohpcl_pkg::S_IDLE);
  assign close       = last_node_i || (cnt_q == CW'(MAX_NODES - 1));
  assign busy_o      = (state_q != ohpcl_pkg::S_IDLE);
  // config registers only change while idle, never under a running sequence
  assign cfg_ready_o = (state_q == ohpcl_pkg::S_IDLE);

  // phi and radius differences of the latched pair
  assign dphi = $signed({node2_q.phi[ohpcl_pkg::PHIW-1], node2_q.phi})
              - $signed({node1_q.phi[ohpcl_pkg::PHIW-1], node1_q.phi});
  assign dphi_abs = dphi[ohpcl_pkg::RW] ? ohpcl_pkg::RW'(-dphi) : dphi[ohpcl_pkg::RW-1:0];
  assign den      = $signed({1'b0, node2_q.r}) - $signed({1'b0, node1_q.r});
  assign den_abs  = den[ohpcl_pkg::RW] ? ohpcl_pkg::RW'(-den) : den[ohpcl_pkg::RW-1:0];
  assign num_abs  = num_q[PRW-1] ? -num_q : num_q;

  // cluster length ratio on the incoming node2 word
  assign c1        = node1_q.cells;
  assign c2        = node_rd_q.cells;
  assign cmax      = (c1 > c2) ? c1 : c2;
  assign cdiff     = (c1 > c2) ? (c1 - c2) : (c2 - c1);
  assign cell_fail = pixel_q && ({cdiff, 8'd0} > (16'(cell_cut_q) * 16'(cmax)));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ohpcl_pkg::S_M_PHI: begin
        mul_a = $signed({2'b00, radius_q});
        mul_b = $signed({2'b00, dphi_abs});
      end
      ohpcl_pkg::S_T_PHI: begin
        mul_a = $signed({2'b00, node2_q.r});
        mul_b = $signed({node1_q.z[ohpcl_pkg::ZW-1], node1_q.z});
      end
      ohpcl_pkg::S_M_B: begin
        mul_a = $signed({2'b00, node1_q.r});
        mul_b = $signed({node2_q.z[ohpcl_pkg::ZW-1], node2_q.z});
      end
      ohpcl_pkg::S_M_C: begin
        mul_a = $signed({2'b00, z0_lim_q});
        mul_b = $signed({2'b00, den_abs});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n1_d     = n1_q;
    n2_d     = n2_q;
    nseen_d  = nseen_q;
    k_d      = k_q;
    npairs_d = npairs_q;
    sweeps_d = sweeps_q;
    ovf_d    = ovf_q;
    chg_d    = chg_q;
    node_ra  = n2_q[NW-1:0];
    cur_ra0  = k_q[NW-1:0];
    cur_ra1  = k_q[NW-1:0];
    cur_we   = 1'b0;
    nxt_we   = 1'b0;
    cur_wa   = k_q[NW-1:0];
    nxt_wa   = k_q[NW-1:0];
    cur_wd   = k_q[NW-1:0];
    nxt_wd   = k_q[NW-1:0];
    seen_we  = 1'b0;
    pair_we  = 1'b0;
    unique case (state_q)
      ohpcl_pkg::S_IDLE: begin
        if (accept) begin
          cnt_d = cnt_q + 1'b1;
          if (close) begin
            n1_d     = '0;
            npairs_d = '0;
            ovf_d    = 1'b0;
            state_d  = ohpcl_pkg::S_N1_RD;
          end
        end
      end
      ohpcl_pkg::S_N1_RD: begin
        node_ra = n1_q[NW-1:0];
        if (CW'(n1_q + 1'b1) >= cnt_q) begin
          k_d     = '0;
          state_d = ohpcl_pkg::S_INIT;
        end else begin
          state_d = ohpcl_pkg::S_N1_LAT;
        end
      end
      ohpcl_pkg::S_N1_LAT: begin
        if (!node_rd_q.ovl) begin
          n1_d    = n1_q + 1'b1;
          state_d = ohpcl_pkg::S_N1_RD;
        end else begin
          n2_d    = n1_q + 1'b1;
          nseen_d = '0;
          state_d = ohpcl_pkg::S_N2_RD;
        end
      end
      ohpcl_pkg::S_N2_RD: begin
        if (n2_q >= cnt_q) begin
          n1_d    = n1_q + 1'b1;
          state_d = ohpcl_pkg::S_N1_RD;
        end else begin
          state_d = ohpcl_pkg::S_N2_CHK;
        end
      end
      ohpcl_pkg::S_N2_CHK: begin
        if (!node_rd_q.ovl || (node_rd_q.module_id == node1_q.module_id)) begin
          n1_d    = n1_q + 1'b1;
          state_d = ohpcl_pkg::S_N1_RD;
        end else if (cell_fail) begin
          n2_d    = n2_q + 1'b1;
          state_d = ohpcl_pkg::S_N2_RD;
        end else begin
          state_d = ohpcl_pkg::S_M_PHI;
        end
      end
      ohpcl_pkg::S_M_PHI: state_d = ohpcl_pkg::S_T_PHI;
      ohpcl_pkg::S_T_PHI: begin
        if ((prod_q > $signed(PRW'(phi_win_q))) || (den == '0)) begin
          n2_d    = n2_q + 1'b1;
          state_d = ohpcl_pkg::S_N2_RD;
        end else begin
          state_d = ohpcl_pkg::S_M_B;
        end
      end
      ohpcl_pkg::S_M_B: state_d = ohpcl_pkg::S_M_C;
      ohpcl_pkg::S_M_C: state_d = ohpcl_pkg::S_T_Z;
      ohpcl_pkg::S_T_Z: begin
        if (!(num_abs < prod_q)) begin
          n2_d    = n2_q + 1'b1;
          state_d = ohpcl_pkg::S_N2_RD;
        end else begin
          k_d     = '0;
          state_d = ohpcl_pkg::S_SEEN_RD;
        end
      end
      ohpcl_pkg::S_SEEN_RD: begin
        if (k_q >= KW'(nseen_q)) begin
          if (nseen_q < CW'(MAX_NODES)) begin
            seen_we = 1'b1;
            nseen_d = nseen_q + 1'b1;
          end
          if (npairs_q < PCW'(MAX_PAIRS)) begin
            pair_we  = 1'b1;
            npairs_d = npairs_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          n2_d    = n2_q + 1'b1;
          state_d = ohpcl_pkg::S_N2_RD;
        end else begin
          state_d = ohpcl_pkg::S_SEEN_CMP;
        end
      end
      ohpcl_pkg::S_SEEN_CMP: begin
        if (seen_rd_q == node2_q.module_id) begin
          n2_d    = n2_q + 1'b1;
          state_d = ohpcl_pkg::S_N2_RD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ohpcl_pkg::S_SEEN_RD;
        end
      end
      ohpcl_pkg::S_INIT: begin
        if (k_q >= KW'(cnt_q)) begin
          k_d      = '0;
          sweeps_d = '0;
          state_d  = (npairs_q == '0) ? ohpcl_pkg::S_O_RD : ohpcl_pkg::S_P_RD;
        end else begin
          cur_we = 1'b1;
          nxt_we = 1'b1;
          k_d    = k_q + 1'b1;
        end
      end
      ohpcl_pkg::S_P_RD: begin
        if (k_q >= KW'(npairs_q)) begin
          k_d     = '0;
          chg_d   = 1'b0;
          state_d = ohpcl_pkg::S_C_RD;
        end else begin
          state_d = ohpcl_pkg::S_P_LAB;
        end
      end
      ohpcl_pkg::S_P_LAB: begin
        cur_ra0 = pair_rd_q[2*NW-1:NW];
        cur_ra1 = pair_rd_q[NW-1:0];
        state_d = ohpcl_pkg::S_P_WR;
      end
      ohpcl_pkg::S_P_WR: begin
        nxt_we = 1'b1;
        if (cur_rd0_q < cur_rd1_q) begin
          nxt_wa = pb_q;
          nxt_wd = cur_rd0_q;
        end else begin
          nxt_wa = pa_q;
          nxt_wd = cur_rd1_q;
        end
        k_d     = k_q + 1'b1;
        state_d = ohpcl_pkg::S_P_RD;
      end
      ohpcl_pkg::S_C_RD: begin
        if (k_q >= KW'(cnt_q)) begin
          k_d = '0;
          if (!chg_q) begin
            state_d = ohpcl_pkg::S_O_RD;
          end else if (sweeps_q == SW'(MAX_SWEEPS - 1)) begin
            ovf_d   = 1'b1;
            state_d = ohpcl_pkg::S_O_RD;
          end else begin
            sweeps_d = sweeps_q + 1'b1;
            state_d  = ohpcl_pkg::S_P_RD;
          end
        end else begin
          state_d = ohpcl_pkg::S_C_WR;
        end
      end
      ohpcl_pkg::S_C_WR: begin
        cur_we = 1'b1;
        cur_wd = nxt_rd_q;
        if (cur_rd0_q != nxt_rd_q) chg_d = 1'b1;
        k_d     = k_q + 1'b1;
        state_d = ohpcl_pkg::S_C_RD;
      end
      ohpcl_pkg::S_O_RD: state_d = ohpcl_pkg::S_O_EM;
      ohpcl_pkg::S_O_EM: begin
        k_d = k_q + 1'b1;
        if (KW'(k_q + 1'b1) >= KW'(cnt_q)) begin
          cnt_d   = '0;
          state_d = ohpcl_pkg::S_IDLE;
        end else begin
          state_d = ohpcl_pkg::S_O_RD;
        end
      end
      default: state_d = ohpcl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ohpcl_pkg::S_IDLE;
      cnt_q    <= '0;
      n1_q     <= '0;
      n2_q     <= '0;
      nseen_q  <= '0;
      k_q      <= '0;
      npairs_q <= '0;
      sweeps_q <= '0;
      ovf_q    <= 1'b0;
      chg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n1_q     <= n1_d;
      n2_q     <= n2_d;
      nseen_q  <= nseen_d;
      k_q      <= k_d;
      npairs_q <= npairs_d;
      sweeps_q <= sweeps_d;
      ovf_q    <= ovf_d;
      chg_q    <= chg_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_cut_q <= 8'd255;
      phi_win_q  <= '0;
      z0_lim_q   <= '0;
      pixel_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ohpcl_pkg::CFG_CELL_CUT: cell_cut_q <= cfg_data_i[7:0];
        ohpcl_pkg::CFG_PHI_WIN:  phi_win_q  <= cfg_data_i;
        ohpcl_pkg::CFG_Z0_LIM:   z0_lim_q   <= cfg_data_i[ohpcl_pkg::RW-1:0];
        ohpcl_pkg::CFG_PIXEL:    pixel_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q == '0)) radius_q <= surface_radius_i;
    if (state_q == ohpcl_pkg::S_N1_LAT) node1_q <= node_rd_q;
    if (state_q == ohpcl_pkg::S_N2_CHK) node2_q <= node_rd_q;
    if ((state_q == ohpcl_pkg::S_M_PHI) || (state_q == ohpcl_pkg::S_T_PHI) ||
        (state_q == ohpcl_pkg::S_M_B) || (state_q == ohpcl_pkg::S_M_C)) begin
      prod_q <= mul_p;
    end
    if (state_q == ohpcl_pkg::S_M_B) a_q <= prod_q;
    if (state_q == ohpcl_pkg::S_M_C) num_q <= a_q - prod_q;
    if (state_q == ohpcl_pkg::S_P_LAB) begin
      pa_q <= pair_rd_q[2*NW-1:NW];
      pb_q <= pair_rd_q[NW-1:0];
    end
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_mem[cnt_q[NW-1:0]] <= '{z: hit_z_i, r: hit_r_i, phi: hit_phi_i,
                                  module_id: module_id_i, cells: cell_count_i,
                                  ovl: in_overlap_i};
    end
    node_rd_q <= node_mem[node_ra];
  end

  // seen-module list
  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[nseen_q[NW-1:0]] <= node2_q.module_id;
    seen_rd_q <= seen_mem[k_q[NW-1:0]];
  end

  // pair list
  always_ff @(posedge clk_i) begin
    if (pair_we) pair_mem[npairs_q[PW-1:0]] <= {n1_q[NW-1:0], n2_q[NW-1:0]};
    pair_rd_q <= pair_mem[k_q[PW-1:0]];
  end

  // label memories
  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd0_q <= cur_mem[cur_ra0];
    cur_rd1_q <= cur_mem[cur_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_q <= nxt_mem[k_q[NW-1:0]];
  end

  // result word, one per node
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == ohpcl_pkg::S_O_EM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ohpcl_pkg::S_O_EM) begin
      node_index_o        <= ohpcl_pkg::OUTIW'(k_q[NW-1:0]);
      merge_target_o      <= ohpcl_pkg::OUTIW'(cur_rd0_q);
      node_kept_o         <= (cur_rd0_q == k_q[NW-1:0]);
      capacity_overflow_o <= ovf_q;
      last_result_o       <= (KW'(k_q + 1'b1) >= KW'(cnt_q));
    end
  end

  // checks
  `OHPCL_ASSERT_ALWAYS(a_last_idle, !(result_valid_o && last_result_o) || !busy_o, "last result while busy")
  `OHPCL_ASSERT_NEXT(a_emit, state_q == ohpcl_pkg::S_O_EM, result_valid_o, "emit lost")
  `OHPCL_ASSERT_ALWAYS(a_pair_cap, npairs_q <= PCW'(MAX_PAIRS), "pair count past cap")

endmodule
